FILE: design/tcw_pkg.sv
// Package for the text console writer: grid geometry, codes and transaction types.
// No dependencies; used by text_console_writer, tcw_checker and tb.
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;

   localparam logic [7:0] CHAR_BLANK   = 8'h20;
   localparam logic [7:0] CHAR_NL      = 8'h0a;
   localparam logic [7:0] CHAR_CR      = 8'h0d;
   localparam logic [7:0] CHAR_BS      = 8'h7f;
   localparam logic [7:0] ATTR_DEFAULT = 8'h07;

   typedef enum logic [1:0] {
      REQ_PUT   = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_COLOR = 2'd2,
      REQ_READ  = 2'd3
   } req_code_type;

   typedef enum logic {
      CSR_FIRST_COL = 1'b0,
      CSR_FIRST_ROW = 1'b1
   } csr_code_type;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [7:0]       char_code;
      logic             move_cursor;
      logic [COL_W-1:0] cell_col;
      logic [ROW_W-1:0] cell_row;
      logic [COL_W-1:0] rect_col_end;
      logic [ROW_W-1:0] rect_row_end;
      logic [7:0]       color;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0] cursor_col;
      logic [ROW_W-1:0] cursor_row;
      logic [10:0]      cursor_loc;
      logic [7:0]       read_char;
      logic [7:0]       read_attr;
   } rsp_type;

   // Linear cell address of a column and row inside the grid
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row);
      cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

endpackage

FILE: design/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: design/text_console_writer.sv
// Text console writer top level: sequencer over the character and attribute stores.
// Depends on tcw_pkg and tcw_ram.
// Newline blanks the rest of the line; a scroll reads then writes each moved cell and
// blanks the bottom row; clear and color step through each cell in turn.
// One transaction at a time.
// Reset: a clearing pass over all CELLS (2000) cells fills both stores; busy stays high.
// Each result is strobed on rsp_valid for one cycle; the receiver cannot stall.
module text_console_writer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tcw_pkg::req_type     req_item,
   output logic                 rsp_valid,
   output tcw_pkg::rsp_type     rsp_item,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [6:0]           csr_wdata
);

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_NEWLINE, ST_POST, ST_SCR_RD, ST_SCR_WR,
      ST_SCR_BLANK, ST_CLEAR, ST_COLOR, ST_READ, ST_FINISH
   } state_type;

   localparam logic [tcw_pkg::COL_W-1:0] LAST_COL = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
   localparam logic [tcw_pkg::ROW_W-1:0] LAST_ROW = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
   localparam logic [tcw_pkg::COL_W-1:0] NUM_COLS = tcw_pkg::COL_W'(tcw_pkg::COLUMNS);
   localparam logic [tcw_pkg::ROW_W-1:0] NUM_ROWS = tcw_pkg::ROW_W'(tcw_pkg::ROWS);

   state_type                     state_ff, state_in;
   logic [tcw_pkg::COL_W-1:0]     win_col_ff, win_col_in;
   logic [tcw_pkg::ROW_W-1:0]     win_row_ff, win_row_in;
   logic [tcw_pkg::COL_W-1:0]     write_col_ff, write_col_in;
   logic [tcw_pkg::ROW_W-1:0]     write_row_ff, write_row_in;
   logic [10:0]                   hw_cursor_ff, hw_cursor_in;
   logic [tcw_pkg::COL_W-1:0]     it_col_ff, it_col_in;
   logic [tcw_pkg::ROW_W-1:0]     it_row_ff, it_row_in;
   logic [tcw_pkg::ADDR_W-1:0]    init_ff, init_in;
   tcw_pkg::req_type              req_ff, req_in;
   logic [tcw_pkg::COL_W-1:0]     col_end_ff, col_end_in;
   logic [tcw_pkg::ROW_W-1:0]     row_end_ff, row_end_in;
   logic [7:0]                    rd_char_ff, rd_char_in;
   logic [7:0]                    rd_attr_ff, rd_attr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type              rsp_ff, rsp_in;

   logic                          accept;
   logic                          char_we, attr_we;
   logic [7:0]                    char_wdata;
   logic [tcw_pkg::COL_W-1:0]     wr_col;
   logic [tcw_pkg::ROW_W-1:0]     wr_row;
   logic [tcw_pkg::ADDR_W-1:0]    wr_addr, rd_addr;
   logic [tcw_pkg::COL_W-1:0]     rd_col;
   logic [tcw_pkg::ROW_W-1:0]     rd_row;
   logic [7:0]                    char_rdata, attr_rdata;
   logic [tcw_pkg::COL_W-1:0]     clip_col;
   logic [tcw_pkg::ROW_W-1:0]     clip_row;
   logic [tcw_pkg::COL_W-1:0]     next_col;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign wr_addr   = (state_ff == ST_INIT) ? init_ff : tcw_pkg::cell_addr(wr_col, wr_row);
   assign rd_addr   = tcw_pkg::cell_addr(rd_col, rd_row);
   assign clip_col  = (req_item.rect_col_end > NUM_COLS) ? NUM_COLS : req_item.rect_col_end;
   assign clip_row  = (req_item.rect_row_end > NUM_ROWS) ? NUM_ROWS : req_item.rect_row_end;
   assign next_col  = write_col_ff + 1'b1;

   tcw_ram #(.WIDTH(8), .DEPTH(tcw_pkg::CELLS)) char_ram (
      .clock(clock), .wr_en(char_we), .wr_addr(wr_addr), .wr_data(char_wdata),
      .rd_addr(rd_addr), .rd_data(char_rdata)
   );

   tcw_ram #(.WIDTH(8), .DEPTH(tcw_pkg::CELLS)) attr_ram (
      .clock(clock), .wr_en(attr_we), .wr_addr(wr_addr),
      .wr_data((state_ff == ST_INIT) ? tcw_pkg::ATTR_DEFAULT : req_ff.color),
      .rd_addr(rd_addr), .rd_data(attr_rdata)
   );

   // Sequencer: next state, store writes and iterator updates
   always_comb begin
      state_in     = state_ff;
      win_col_in   = win_col_ff;
      win_row_in   = win_row_ff;
      write_col_in = write_col_ff;
      write_row_in = write_row_ff;
      hw_cursor_in = hw_cursor_ff;
      it_col_in    = it_col_ff;
      it_row_in    = it_row_ff;
      init_in      = init_ff;
      req_in       = req_ff;
      col_end_in   = col_end_ff;
      row_end_in   = row_end_ff;
      rd_char_in   = rd_char_ff;
      rd_attr_in   = rd_attr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      char_we      = 1'b0;
      attr_we      = 1'b0;
      char_wdata   = tcw_pkg::CHAR_BLANK;
      wr_col       = it_col_ff;
      wr_row       = it_row_ff;
      rd_col       = it_col_ff;
      rd_row       = it_row_ff + 1'b1;

      // Saturating window register writes
      if (csr_we) begin
         case (csr_index)
            tcw_pkg::CSR_FIRST_COL: win_col_in = (csr_wdata > LAST_COL) ? LAST_COL : csr_wdata;
            tcw_pkg::CSR_FIRST_ROW: win_row_in = (csr_wdata[4:0] > LAST_ROW) ? LAST_ROW
                                                                             : csr_wdata[4:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_INIT: begin
            char_we    = 1'b1;
            attr_we    = 1'b1;
            char_wdata = 8'h00;
            init_in    = init_ff + 1'b1;
            if (init_ff == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            wr_col = write_col_ff;
            wr_row = write_row_ff;
            rd_col = req_item.cell_col;
            rd_row = req_item.cell_row;
            if (accept) begin
               req_in     = req_item;
               rd_char_in = 8'h00;
               rd_attr_in = 8'h00;
               case (req_item.req_type)
                  tcw_pkg::REQ_PUT: begin
                     state_in = ST_POST;
                     if (req_item.char_code == tcw_pkg::CHAR_NL) begin
                        it_col_in = write_col_ff;
                        it_row_in = write_row_ff;
                        state_in  = ST_NEWLINE;
                     end else if (req_item.char_code == tcw_pkg::CHAR_CR) begin
                        write_col_in = win_col_ff;
                     end else if (req_item.char_code == tcw_pkg::CHAR_BS) begin
                        // step back and blank the cell
                        if (write_col_ff != '0) begin
                           wr_col       = write_col_ff - 1'b1;
                           char_we      = 1'b1;
                           write_col_in = write_col_ff - 1'b1;
                        end
                     end else begin
                        char_we    = (req_item.char_code != 8'h00);
                        char_wdata = req_item.char_code;
                        if (next_col >= NUM_COLS) begin
                           write_col_in = win_col_ff;
                           write_row_in = write_row_ff + 1'b1;
                        end else begin
                           write_col_in = next_col;
                        end
                     end
                  end
                  tcw_pkg::REQ_CLEAR: begin
                     it_col_in = win_col_ff;
                     it_row_in = win_row_ff;
                     state_in  = ST_CLEAR;
                  end
                  tcw_pkg::REQ_COLOR: begin
                     it_col_in  = req_item.cell_col;
                     it_row_in  = req_item.cell_row;
                     col_end_in = clip_col;
                     row_end_in = clip_row;
                     if (req_item.cell_col < clip_col && req_item.cell_row < clip_row) begin
                        state_in = ST_COLOR;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  default: begin
                     if (req_item.cell_col < NUM_COLS && req_item.cell_row < NUM_ROWS) begin
                        state_in = ST_READ;
                     end else begin
                        rd_char_in = tcw_pkg::CHAR_BLANK;
                        state_in   = ST_FINISH;
                     end
                  end
               endcase
            end
         end
         ST_NEWLINE: begin
            char_we   = 1'b1;
            it_col_in = it_col_ff + 1'b1;
            if (it_col_ff == LAST_COL) begin
               write_col_in = win_col_ff;
               write_row_in = write_row_ff + 1'b1;
               state_in     = ST_POST;
            end
         end
         ST_POST: begin
            // scroll when the write row has passed the bottom
            if (write_row_ff >= NUM_ROWS) begin
               write_row_in = LAST_ROW;
               write_col_in = win_col_ff;
               it_col_in    = win_col_ff;
               it_row_in    = win_row_ff;
               state_in     = ST_SCR_RD;
               if (win_row_ff == LAST_ROW) begin
                  it_col_in = '0;
                  it_row_in = LAST_ROW;
                  state_in  = ST_SCR_BLANK;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SCR_RD: begin
            state_in = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            char_we    = 1'b1;
            char_wdata = (char_rdata != 8'h00) ? char_rdata : tcw_pkg::CHAR_BLANK;
            it_col_in  = it_col_ff + 1'b1;
            state_in   = ST_SCR_RD;
            if (it_col_ff == LAST_COL) begin
               it_col_in = win_col_ff;
               it_row_in = it_row_ff + 1'b1;
               if (it_row_ff + 1'b1 == LAST_ROW) begin
                  it_col_in = '0;
                  state_in  = ST_SCR_BLANK;
               end
            end
         end
         ST_SCR_BLANK: begin
            char_we   = 1'b1;
            it_col_in = it_col_ff + 1'b1;
            if (it_col_ff == LAST_COL) begin
               state_in = ST_FINISH;
            end
         end
         ST_CLEAR: begin
            char_we   = 1'b1;
            it_col_in = it_col_ff + 1'b1;
            if (it_col_ff == LAST_COL) begin
               it_col_in = win_col_ff;
               it_row_in = it_row_ff + 1'b1;
               if (it_row_ff == LAST_ROW) begin
                  write_col_in = win_col_ff;
                  write_row_in = win_row_ff;
                  state_in     = ST_FINISH;
               end
            end
         end
         ST_COLOR: begin
            attr_we   = 1'b1;
            it_col_in = it_col_ff + 1'b1;
            if (it_col_ff + 1'b1 == col_end_ff) begin
               it_col_in = req_ff.cell_col;
               it_row_in = it_row_ff + 1'b1;
               if (it_row_ff + 1'b1 == row_end_ff) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_READ: begin
            rd_char_in = (char_rdata != 8'h00) ? char_rdata : tcw_pkg::CHAR_BLANK;
            rd_attr_in = attr_rdata;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            // program the cursor and present the result
            if (req_ff.req_type == tcw_pkg::REQ_PUT && req_ff.move_cursor) begin
               hw_cursor_in = tcw_pkg::cell_addr(write_col_ff, write_row_ff);
            end
            rsp_in.cursor_col = write_col_ff;
            rsp_in.cursor_row = write_row_ff;
            rsp_in.cursor_loc = hw_cursor_in;
            rsp_in.read_char  = rd_char_ff;
            rsp_in.read_attr  = rd_attr_ff;
            rsp_valid_in      = 1'b1;
            state_in          = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         win_col_ff   <= '0;
         win_row_ff   <= '0;
         write_col_ff <= '0;
         write_row_ff <= '0;
         hw_cursor_ff <= '0;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_col_ff   <= win_col_in;
         win_row_ff   <= win_row_in;
         write_col_ff <= write_col_in;
         write_row_ff <= write_row_in;
         hw_cursor_ff <= hw_cursor_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      it_col_ff  <= it_col_in;
      it_row_ff  <= it_row_in;
      req_ff     <= req_in;
      col_end_ff <= col_end_in;
      row_end_ff <= row_end_in;
      rd_char_ff <= rd_char_in;
      rd_attr_ff <= rd_attr_in;
      rsp_ff     <= rsp_in;
   end

   // A result strobe follows only the finish step
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_FINISH))
      else $error("result strobe without finish step");

   // No store write while idle without an accepted transaction
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !accept) |-> (!char_we && !attr_we))
      else $error("store write while idle");

   // Write position is inside the grid whenever the block is idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (write_row_ff < NUM_ROWS && write_col_ff < NUM_COLS))
      else $error("write position outside grid");

endmodule

FILE: sim/tcw_checker.sv
// Checker for the text console writer: watches the request and result channels,
// predicts each result from its own copy of the grid and compares the whole result.
// Depends on tcw_pkg.
module tcw_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  tcw_pkg::req_type req_item,
   input  logic             rsp_valid,
   input  tcw_pkg::rsp_type rsp_item,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [6:0]       csr_wdata,
   output int               fail_count,
   output int               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0]       grid_char [tcw_pkg::CELLS];
   logic [7:0]       grid_attr [tcw_pkg::CELLS];
   int unsigned      pos_col, pos_row, cursor_pos, win_col, win_row;
   tcw_pkg::rsp_type expected_rsps [$];

   function automatic int unsigned idx(int unsigned c, int unsigned r);
      return (r % tcw_pkg::ROWS) * tcw_pkg::COLUMNS + (c % tcw_pkg::COLUMNS);
   endfunction

   function automatic void blank_line(int unsigned c0, int unsigned r);
      for (int unsigned c = c0; c < tcw_pkg::COLUMNS; c++)
         grid_char[idx(c, r)] = tcw_pkg::CHAR_BLANK;
   endfunction

   function automatic void set_cursor(int unsigned c, int unsigned r);
      cursor_pos = (r * tcw_pkg::COLUMNS + c) & 11'h7ff;
   endfunction

   function automatic void scroll_window();
      logic [7:0] b;
      for (int unsigned r = win_row; r + 1 < tcw_pkg::ROWS; r++)
         for (int unsigned c = win_col; c < tcw_pkg::COLUMNS; c++) begin
            b = grid_char[idx(c, r + 1)];
            grid_char[idx(c, r)] = (b != 0) ? b : tcw_pkg::CHAR_BLANK;
         end
      pos_row = tcw_pkg::ROWS - 1;
      pos_col = win_col;
      blank_line(0, pos_row);
   endfunction

   function automatic void put_char(logic [7:0] ch, logic mv);
      if (ch == tcw_pkg::CHAR_NL) begin
         blank_line(pos_col, pos_row);
         pos_col = win_col;
         pos_row++;
      end else if (ch == tcw_pkg::CHAR_CR) begin
         pos_col = win_col;
      end else if (ch == tcw_pkg::CHAR_BS) begin
         if (pos_col > 0) begin
            pos_col--;
            grid_char[idx(pos_col, pos_row)] = tcw_pkg::CHAR_BLANK;
            if (mv) set_cursor(pos_col, pos_row);
         end
      end else begin
         if (ch != 0) grid_char[idx(pos_col, pos_row)] = ch;
         pos_col++;
         if (pos_col >= tcw_pkg::COLUMNS) begin
            pos_col = win_col;
            pos_row++;
         end
      end
      if (pos_row >= tcw_pkg::ROWS) scroll_window();
      if (mv) set_cursor(pos_col, pos_row);
   endfunction

   // Compute the result of one accepted request
   function automatic tcw_pkg::rsp_type predict_console(tcw_pkg::req_type rq);
      tcw_pkg::rsp_type rs;
      int unsigned      c1, r1;
      rs = '0;
      case (tcw_pkg::req_code_type'(rq.req_type))
         tcw_pkg::REQ_PUT: put_char(rq.char_code, rq.move_cursor);
         tcw_pkg::REQ_CLEAR: begin
            for (int unsigned r = win_row; r < tcw_pkg::ROWS; r++) blank_line(win_col, r);
            pos_col = win_col;
            pos_row = win_row;
         end
         tcw_pkg::REQ_COLOR: begin
            c1 = (rq.rect_col_end > tcw_pkg::COLUMNS) ? tcw_pkg::COLUMNS : rq.rect_col_end;
            r1 = (rq.rect_row_end > tcw_pkg::ROWS) ? tcw_pkg::ROWS : rq.rect_row_end;
            for (int unsigned r = rq.cell_row; r < r1; r++)
               for (int unsigned c = rq.cell_col; c < c1; c++)
                  grid_attr[idx(c, r)] = rq.color;
         end
         default: begin
            if (rq.cell_col < tcw_pkg::COLUMNS && rq.cell_row < tcw_pkg::ROWS) begin
               rs.read_char = grid_char[idx(rq.cell_col, rq.cell_row)];
               if (rs.read_char == 0) rs.read_char = tcw_pkg::CHAR_BLANK;
               rs.read_attr = grid_attr[idx(rq.cell_col, rq.cell_row)];
            end else begin
               rs.read_char = tcw_pkg::CHAR_BLANK;
            end
         end
      endcase
      rs.cursor_col = pos_col[tcw_pkg::COL_W-1:0];
      rs.cursor_row = pos_row[tcw_pkg::ROW_W-1:0];
      rs.cursor_loc = cursor_pos[10:0];
      return rs;
   endfunction

   // Track requests, register writes and results
   always @(posedge clock) begin
      tcw_pkg::rsp_type got, want;
      int unsigned      v;
      if (reset) begin
         for (int i = 0; i < tcw_pkg::CELLS; i++) begin
            grid_char[i] = 8'h00;
            grid_attr[i] = tcw_pkg::ATTR_DEFAULT;
         end
         pos_col = 0; pos_row = 0; cursor_pos = 0; win_col = 0; win_row = 0;
         expected_rsps.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid) begin
            got = rsp_item;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result %p", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  $display("%0t: result mismatch expected %p actual %p", $time, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_we) begin
            if (tcw_pkg::csr_code_type'(csr_index) == tcw_pkg::CSR_FIRST_COL) begin
               v = csr_wdata;
               win_col = (v > tcw_pkg::COLUMNS - 1) ? tcw_pkg::COLUMNS - 1 : v;
            end else begin
               v = csr_wdata[4:0];
               win_row = (v > tcw_pkg::ROWS - 1) ? tcw_pkg::ROWS - 1 : v;
            end
         end
         if (start && !busy) expected_rsps.push_back(predict_console(req_item));
      end
      pending_count = expected_rsps.size();
   end
endmodule

FILE: sim/tb.sv
// Testbench top for the text console writer: clock, reset, stimulus and verdict.
// Depends on tcw_pkg, text_console_writer and tcw_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock, reset, start, busy, rsp_valid, csr_we, csr_index;
   logic [6:0]       csr_wdata;
   tcw_pkg::req_type req_item;
   tcw_pkg::rsp_type rsp_item;
   int               fail_count, pending_count, idle_cycles;

   text_console_writer u_top (.*);
   tcw_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Watchdog: count cycles with no transaction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 40000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      repeat (n) @(negedge clock);
   endtask

   // Issue one request; hold it past acceptance until the block is idle again, so it may be taken twice
   task automatic send_request(tcw_pkg::req_type rq);
      start    <= 1'b1;
      req_item <= rq;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic issue(tcw_pkg::req_code_type op, int ch, int mv, int c, int r,
                        int ce, int re, int clr);
      tcw_pkg::req_type rq;
      rq.req_type     = op;
      rq.char_code    = 8'(ch);
      rq.move_cursor  = 1'(mv);
      rq.cell_col     = 7'(c);
      rq.cell_row     = 5'(r);
      rq.rect_col_end = 7'(ce);
      rq.rect_row_end = 5'(re);
      rq.color        = 8'(clr);
      send_request(rq);
      gap();
   endtask

   // Wait until every result is in, then let the block settle before a write
   task automatic drain_then_write(tcw_pkg::csr_code_type ix, logic [6:0] val);
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= ix;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_request();
      tcw_pkg::req_type rq;
      int               k;
      rq = tcw_pkg::req_type'($bits(tcw_pkg::req_type)'({$urandom, $urandom}));
      k = $urandom_range(0, 99);
      if (k < 70) begin
         rq.req_type = tcw_pkg::REQ_PUT;
         case ($urandom_range(0, 9))
            0: rq.char_code = tcw_pkg::CHAR_NL;
            1: rq.char_code = tcw_pkg::CHAR_CR;
            2: rq.char_code = tcw_pkg::CHAR_BS;
            default: rq.char_code = 8'($urandom_range(32, 126));
         endcase
         if ($urandom_range(0, 19) == 0) rq.char_code = 8'($urandom);
      end else if (k < 72) begin
         rq.req_type = tcw_pkg::REQ_CLEAR;
      end else if (k < 82) begin
         // keep rectangles small most of the time
         rq.req_type = tcw_pkg::REQ_COLOR;
         if ($urandom_range(0, 9) != 0) begin
            rq.rect_col_end = 7'(rq.cell_col + $urandom_range(0, 4));
            rq.rect_row_end = 5'(rq.cell_row + $urandom_range(0, 2));
         end
      end else begin
         rq.req_type = tcw_pkg::REQ_READ;
         if ($urandom_range(0, 7) != 0) begin
            rq.cell_col = 7'($urandom_range(0, tcw_pkg::COLUMNS - 1));
            rq.cell_row = 5'($urandom_range(0, tcw_pkg::ROWS - 1));
         end
      end
      send_request(rq);
      gap();
   endtask

   initial begin
      reset = 1; start = 0; csr_we = 0; csr_index = 0; csr_wdata = 0;
      req_item = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: every operation, control bytes, edges of the fields
      issue(tcw_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0);
      issue(tcw_pkg::REQ_PUT, 8'h00, 1, 0, 0, 0, 0, 0);
      issue(tcw_pkg::REQ_PUT, 8'hff, 1, 0, 0, 0, 0, 0);
      issue(tcw_pkg::REQ_PUT, tcw_pkg::CHAR_BS, 1, 0, 0, 0, 0, 0);
      issue(tcw_pkg::REQ_PUT, tcw_pkg::CHAR_BS, 1, 0, 0, 0, 0, 0);
      issue(tcw_pkg::REQ_PUT, tcw_pkg::CHAR_BS, 1, 0, 0, 0, 0, 0);
      issue(tcw_pkg::REQ_PUT, 8'h41, 0, 0, 0, 0, 0, 0);
      issue(tcw_pkg::REQ_PUT, tcw_pkg::CHAR_NL, 1, 0, 0, 0, 0, 0);
      issue(tcw_pkg::REQ_PUT, tcw_pkg::CHAR_CR, 1, 0, 0, 0, 0, 0);
      issue(tcw_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0);
      issue(tcw_pkg::REQ_READ, 0, 1, 127, 31, 0, 0, 0);
      issue(tcw_pkg::REQ_READ, 0, 0, 79, 31, 0, 0, 0);
      issue(tcw_pkg::REQ_COLOR, 0, 0, 0, 0, 127, 31, 8'hff);
      issue(tcw_pkg::REQ_COLOR, 0, 0, 5, 5, 3, 3, 8'h00);
      issue(tcw_pkg::REQ_COLOR, 0, 0, 78, 23, 80, 25, 8'h5a);
      issue(tcw_pkg::REQ_READ, 0, 0, 79, 24, 0, 0, 0);
      // fill rows to force a scroll
      for (int i = 0; i < 26; i++) issue(tcw_pkg::REQ_PUT, tcw_pkg::CHAR_NL, i % 2, 0, 0, 0, 0, 0);
      for (int i = 0; i < 81; i++) issue(tcw_pkg::REQ_PUT, 8'h61 + i % 26, 1, 0, 0, 0, 0, 0);
      issue(tcw_pkg::REQ_READ, 0, 0, 0, 24, 0, 0, 0);
      issue(tcw_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0);

      // Random phases over several window settings, extremes included
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               drain_then_write(tcw_pkg::CSR_FIRST_COL, 7'h7f);
               drain_then_write(tcw_pkg::CSR_FIRST_ROW, 7'h1f);
            end
            1: begin
               drain_then_write(tcw_pkg::CSR_FIRST_COL, 7'd0);
               drain_then_write(tcw_pkg::CSR_FIRST_ROW, 7'd0);
            end
            2: begin
               drain_then_write(tcw_pkg::CSR_FIRST_COL, 7'd79);
               drain_then_write(tcw_pkg::CSR_FIRST_ROW, 7'd24);
            end
            default: begin
               drain_then_write(tcw_pkg::CSR_FIRST_COL, 7'($urandom));
               drain_then_write(tcw_pkg::CSR_FIRST_ROW, 7'($urandom));
            end
         endcase
         for (int i = 0; i < 35; i++) random_request();
      end

      while (pending_count != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
